// ----- rtl/wnc_pkg.sv -----
package wnc_pkg;

    localparam int PIX_W       = 8;
    localparam int COORD_W     = 12;
    localparam int CFG_W       = 13;
    localparam int SUM_W       = 5;
    localparam int COORD_LIMIT = 4096;

    localparam logic [CFG_W-1:0] DIM_RESET = 13'd512;
    localparam logic [CFG_W-1:0] DIM_LIMIT = 13'd4096;

    localparam logic [SUM_W-1:0] W_CENTER = 5'd1;
    localparam logic [SUM_W-1:0] W_EDGE   = 5'd2;
    localparam logic [SUM_W-1:0] W_CORNER = 5'd4;

    // Job queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef logic [PIX_W-1:0]   t_pix;
    typedef logic [COORD_W-1:0] t_coord;

    // One accepted pixel that causes at least one result, with its neighborhood.
    typedef struct packed {
        t_coord          row;
        t_coord          col;
        t_pix            pix;
        logic            has_int;
        logic            has_bdr;
        t_pix            center;
        logic [3:0][PIX_W-1:0] corners;
        logic [3:0][PIX_W-1:0] edges;
    } t_job;

endpackage

// ----- rtl/wnc_front.sv -----
module wnc_front #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  wnc_pkg::t_cfg_reg           i_cfg_idx,
    input  logic [wnc_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [wnc_pkg::PIX_W-1:0]   i_pixel,
    input  logic                        i_frame_start,
    input  logic [wnc_pkg::Q_CW-1:0]    i_q_count,
    output logic                        o_job_valid,
    output wnc_pkg::t_job               o_job
);
    import wnc_pkg::*;

    localparam int LIM_W = (MAX_WIDTH < COORD_LIMIT) ? MAX_WIDTH : COORD_LIMIT;
    localparam int DEPTH = LIM_W;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [CFG_W-1:0] LIM_W_V = CFG_W'(LIM_W);

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    t_coord           r_row;
    t_coord           r_col;

    t_pix             r_older [DEPTH];
    t_pix             r_newer [DEPTH];
    t_pix             r_rd_older;
    t_pix             r_rd_newer;
    logic             r_fwd;
    t_pix             r_fwd_data;

    logic             r_s1_valid;
    logic [AW-1:0]    r_s1_addr;
    t_coord           r_s1_row;
    t_coord           r_s1_col;
    t_pix             r_s1_pix;
    logic             r_s1_int;
    logic             r_s1_bdr;
    t_pix             r_win [6];

    logic             w_acc;
    logic [CFG_W-1:0] w_row0;
    logic [CFG_W-1:0] w_col0;
    t_coord           w_r;
    t_coord           w_c;
    logic             w_last_row;
    logic             w_last_col;
    logic [AW-1:0]    w_addr;
    t_pix             w_top;

    // Room is counted for the item already in flight toward the queue.
    assign o_ready = ((Q_CW+1)'(i_q_count) + (Q_CW+1)'(r_s1_valid)) < (Q_CW+1)'(Q_DEPTH);
    assign w_acc   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_RESET;
            r_height <= DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH: begin
                    if (i_cfg_data == '0) begin
                        r_width <= CFG_W'(1);
                    end else if (i_cfg_data > LIM_W_V) begin
                        r_width <= LIM_W_V;
                    end else begin
                        r_width <= i_cfg_data;
                    end
                end
                REG_HEIGHT: begin
                    if (i_cfg_data == '0) begin
                        r_height <= CFG_W'(1);
                    end else if (i_cfg_data > DIM_LIMIT) begin
                        r_height <= DIM_LIMIT;
                    end else begin
                        r_height <= i_cfg_data;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Position of the arriving pixel, after resync and out-of-frame wrapping.
    always_comb begin
        if (i_frame_start) begin
            w_row0 = '0;
            w_col0 = '0;
        end else if ({1'b0, r_col} >= r_width) begin
            w_row0 = {1'b0, r_row} + CFG_W'(1);
            w_col0 = '0;
        end else begin
            w_row0 = {1'b0, r_row};
            w_col0 = {1'b0, r_col};
        end
        if (w_row0 >= r_height) begin
            w_row0 = '0;
        end
        w_r        = w_row0[COORD_W-1:0];
        w_c        = w_col0[COORD_W-1:0];
        w_last_row = ({1'b0, w_r} == (r_height - CFG_W'(1)));
        w_last_col = ({1'b0, w_c} == (r_width - CFG_W'(1)));
        w_addr     = w_c[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_acc;
            if (w_acc) begin
                if (w_last_col) begin
                    r_col <= '0;
                    r_row <= w_last_row ? '0 : w_r + COORD_W'(1);
                end else begin
                    r_col <= w_c + COORD_W'(1);
                    r_row <= w_r;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rd_older     <= r_older[w_addr];
            r_rd_newer     <= r_newer[w_addr];
            r_newer[w_addr] <= i_pixel;
        end
        if (r_s1_valid) begin
            r_older[r_s1_addr] <= r_rd_newer;
        end
    end

    // The older line is written in the cycle after the read, so a pixel at the
    // same column right behind takes the value being written.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_fwd      <= r_s1_valid && (r_s1_addr == w_addr);
            r_fwd_data <= r_rd_newer;
            r_s1_addr  <= w_addr;
            r_s1_row   <= w_r;
            r_s1_col   <= w_c;
            r_s1_pix   <= i_pixel;
            r_s1_int   <= (w_r >= COORD_W'(2)) && (w_c >= COORD_W'(2));
            r_s1_bdr   <= (w_r == '0) || w_last_row || (w_c == '0) || w_last_col;
        end
    end

    assign w_top = r_fwd ? r_fwd_data : r_rd_older;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (r_s1_valid) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= w_top;
            r_win[1] <= r_rd_newer;
            r_win[2] <= r_s1_pix;
        end
    end

    assign o_job_valid = r_s1_valid && (r_s1_int || r_s1_bdr);

    always_comb begin
        o_job.row     = r_s1_row;
        o_job.col     = r_s1_col;
        o_job.pix     = r_s1_pix;
        o_job.has_int = r_s1_int;
        o_job.has_bdr = r_s1_bdr;
        o_job.center  = r_win[1];
        o_job.corners = {r_win[3], r_win[5], w_top, r_s1_pix};
        o_job.edges   = {r_win[0], r_win[2], r_win[4], r_rd_newer};
    end

endmodule

// ----- rtl/wnc_queue.sv -----
module wnc_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  wnc_pkg::t_job            i_job,
    input  logic                     i_pop,
    output logic                     o_valid,
    output wnc_pkg::t_job            o_head,
    output logic [wnc_pkg::Q_CW-1:0] o_count
);
    import wnc_pkg::*;

    t_job              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_CW-1:0]   r_count;
    logic              w_pop;

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            r_count <= r_count + Q_CW'(i_push) - Q_CW'(w_pop);
        end
    end

endmodule

// ----- rtl/wnc_back.sv -----
module wnc_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  wnc_pkg::t_job                i_head,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [wnc_pkg::COORD_W-1:0]  o_out_row,
    output logic [wnc_pkg::COORD_W-1:0]  o_out_col,
    output logic [wnc_pkg::PIX_W-1:0]    o_out_value,
    output logic                         o_last_of_run
);
    import wnc_pkg::*;

    logic             r_valid, n_valid;
    logic             r_second, n_second;
    t_coord           r_row, n_row;
    t_coord           r_col, n_col;
    t_pix             r_val, n_val;
    logic             r_last, n_last;
    logic [SUM_W-1:0] w_sum;
    logic             w_load;

    always_comb begin
        w_sum = W_CENTER;
        for (int k = 0; k < 4; k++) begin
            if (i_head.center <= i_head.corners[k]) begin
                w_sum = w_sum + W_CORNER;
            end
            if (i_head.center <= i_head.edges[k]) begin
                w_sum = w_sum + W_EDGE;
            end
        end
    end

    assign w_load = !r_valid || i_ready;

    // A job with both results gives the interior one first, then the border one.
    always_comb begin
        o_pop    = 1'b0;
        n_valid  = r_valid && !i_ready;
        n_second = r_second;
        n_row    = r_row;
        n_col    = r_col;
        n_val    = r_val;
        n_last   = r_last;
        if (i_q_valid && w_load) begin
            n_valid = 1'b1;
            if (i_head.has_int && !r_second) begin
                n_row  = i_head.row - COORD_W'(1);
                n_col  = i_head.col - COORD_W'(1);
                n_val  = PIX_W'(w_sum);
                n_last = !i_head.has_bdr;
                if (i_head.has_bdr) begin
                    n_second = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end else begin
                n_row    = i_head.row;
                n_col    = i_head.col;
                n_val    = i_head.pix;
                n_last   = 1'b1;
                n_second = 1'b0;
                o_pop    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_col  <= n_col;
        r_val  <= n_val;
        r_last <= n_last;
    end

    assign o_valid       = r_valid;
    assign o_out_row     = r_row;
    assign o_out_col     = r_col;
    assign o_out_value   = r_val;
    assign o_last_of_run = r_last;

endmodule

// ----- rtl/weighted_neighbor_compare_3x3_top.sv -----
// 3x3 weighted neighbor compare over a raster stream of 8-bit grey pixels.
// Input channel: i_valid/o_ready carry one pixel per request, with
// i_frame_start marking row 0, column 0. Output channel: o_valid/i_ready
// carry one result per request: row, column, value and a flag on the last
// result caused by an input pixel. A pixel gives zero, one or two results;
// with two, the interior result of the pixel one row up and one column left
// comes first and the border copy of the arriving pixel second.
// An accepted pixel is registered in the front, queued as a job, then loaded
// into the output register. Throughput: one pixel per cycle while each pixel
// gives at most one result and the receiver stays ready; a pixel with two
// results uses the single output register twice, so the output sets the rate.
// A four-entry job queue sits between the line-buffer front and the output
// back, so a stalled receiver fills the queue and then drops o_ready.
// Image width and height are written through i_cfg_we/i_cfg_idx/i_cfg_data
// while the stream is idle. Reset sets both to 512, the position to row 0,
// column 0, and empties the queue and output; line buffers are not cleared.
module weighted_neighbor_compare_3x3_top #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  wnc_pkg::t_cfg_reg            i_cfg_idx,
    input  logic [wnc_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [wnc_pkg::PIX_W-1:0]    i_pixel,
    input  logic                         i_frame_start,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [wnc_pkg::COORD_W-1:0]  o_out_row,
    output logic [wnc_pkg::COORD_W-1:0]  o_out_col,
    output logic [wnc_pkg::PIX_W-1:0]    o_out_value,
    output logic                         o_last_of_run
);
    import wnc_pkg::*;

    logic            w_job_valid;
    t_job            w_job;
    logic            w_q_valid;
    t_job            w_head;
    logic            w_pop;
    logic [Q_CW-1:0] w_q_count;

    wnc_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel      (i_pixel),
        .i_frame_start(i_frame_start),
        .i_q_count    (w_q_count),
        .o_job_valid  (w_job_valid),
        .o_job        (w_job)
    );

    wnc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_job_valid),
        .i_job  (w_job),
        .i_pop  (w_pop),
        .o_valid(w_q_valid),
        .o_head (w_head),
        .o_count(w_q_count)
    );

    wnc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_out_value  (o_out_value),
        .o_last_of_run(o_last_of_run)
    );

endmodule

// ----- tb/wnc_result_check.sv -----
`timescale 1ns / 1ps

module wnc_result_check #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  wnc_pkg::t_cfg_reg            i_cfg_idx,
    input  logic [wnc_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  wnc_pkg::t_pix                i_pixel,
    input  logic                         i_frame_start,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  wnc_pkg::t_coord              i_out_row,
    input  wnc_pkg::t_coord              i_out_col,
    input  wnc_pkg::t_pix                i_out_value,
    input  logic                         i_out_last,
    output int                           o_fail_count,
    output int                           o_pending
);
    import wnc_pkg::*;

    localparam int WIDTH_CAP = (MAX_WIDTH < COORD_LIMIT) ? MAX_WIDTH : COORD_LIMIT;

    typedef struct packed {
        t_coord row;
        t_coord col;
        t_pix   value;
        logic   last;
    } t_result;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    t_pix             two_up[MAX_WIDTH];
    t_pix             one_up[MAX_WIDTH];
    // Entries 0..2 hold the column just left of the arriving pixel (top, middle,
    // bottom), entries 3..5 the column before that.
    t_pix             win[6];
    int               row_pos;
    int               col_pos;
    t_result          results_owed[$];
    int               fail_count = 0;

    function automatic int effective_dim(logic [CFG_W-1:0] v, int cap);
        int d;
        d = (v == '0) ? 1 : int'(v);
        if (d > cap) d = cap;
        return d;
    endfunction

    function automatic int weigh(t_pix ctr, t_pix nb, int wt);
        return (ctr <= nb) ? wt : 0;
    endfunction

    function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic compute_neighbor_results(input t_pix pix, input logic fs);
        int      w;
        int      h;
        int      r;
        int      c;
        int      sum;
        int      n;
        t_pix    top;
        t_pix    mid;
        t_pix    ctr;
        t_result found[2];
        w = effective_dim(width_reg, WIDTH_CAP);
        h = effective_dim(height_reg, COORD_LIMIT);
        n = 0;
        if (fs) begin
            row_pos = 0;
            col_pos = 0;
        end else if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        r = row_pos;
        c = col_pos;
        if (c >= MAX_WIDTH) c = 0;
        top = two_up[c];
        mid = one_up[c];

        // The arriving pixel closes the window centered one row up, one column left.
        if (r >= 2 && c >= 2) begin
            ctr = win[1];
            sum = W_CENTER;
            sum += weigh(ctr, win[3], W_CORNER) + weigh(ctr, win[5], W_CORNER);
            sum += weigh(ctr, top, W_CORNER) + weigh(ctr, pix, W_CORNER);
            sum += weigh(ctr, win[0], W_EDGE) + weigh(ctr, win[2], W_EDGE);
            sum += weigh(ctr, win[4], W_EDGE) + weigh(ctr, mid, W_EDGE);
            found[n] = '{row: t_coord'(r - 1), col: t_coord'(c - 1),
                         value: t_pix'(sum), last: 1'b0};
            n++;
        end

        two_up[c] = mid;
        one_up[c] = pix;
        win[3] = win[0];
        win[4] = win[1];
        win[5] = win[2];
        win[0] = top;
        win[1] = mid;
        win[2] = pix;

        if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
            found[n] = '{row: t_coord'(r), col: t_coord'(c), value: pix, last: 1'b0};
            n++;
        end
        if (n > 0) found[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) results_owed.push_back(found[k]);

        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            width_reg  = DIM_RESET;
            height_reg = DIM_RESET;
            for (int k = 0; k < 6; k++) win[k] = '0;
            row_pos = 0;
            col_pos = 0;
            results_owed.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_WIDTH) width_reg = i_cfg_data;
                else height_reg = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (results_owed.size() == 0) begin
                    $error("unexpected result: row %0d col %0d value %0d last %0d",
                           i_out_row, i_out_col, i_out_value, i_out_last);
                    fail_count++;
                end else begin
                    want = results_owed.pop_front();
                    check_field("out_row", want.row, i_out_row);
                    check_field("out_col", want.col, i_out_col);
                    check_field("out_value", want.value, i_out_value);
                    check_field("last_of_run", want.last, i_out_last);
                end
            end
            if (i_in_valid && i_in_ready) compute_neighbor_results(i_pixel, i_frame_start);
        end
        o_fail_count <= fail_count;
        o_pending    <= results_owed.size();
    end

endmodule

// ----- tb/tb_weighted_neighbor_compare_3x3_top.sv -----
`timescale 1ns / 1ps

module tb_weighted_neighbor_compare_3x3_top;
    import wnc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 14;
    localparam int PHASE_ITEMS  = 60;
    localparam int WIDE_ITEMS   = 40;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    t_cfg_reg         i_cfg_idx     = REG_WIDTH;
    logic [CFG_W-1:0] i_cfg_data    = '0;
    logic             i_valid       = 1'b0;
    logic             o_ready;
    t_pix             i_pixel       = '0;
    logic             i_frame_start = 1'b0;
    logic             o_valid;
    logic             i_ready       = 1'b0;
    t_coord           o_out_row;
    t_coord           o_out_col;
    t_pix             o_out_value;
    logic             o_last_of_run;

    int               fail_count;
    int               pending;
    int               send_idle_pct = 0;
    int               stall_pct     = 0;
    int               cycles        = 0;
    int               prev_width    = 512;
    t_pix             level         = '0;

    // Small frame whose interior covers the full sum, equal neighbors and extremes.
    t_pix probe_frame[16] = '{8'd10,  8'd20,  8'd30,  8'd40,
                              8'd50,  8'd0,   8'd255, 8'd60,
                              8'd0,   8'd128, 8'd128, 8'd255,
                              8'd255, 8'd0,   8'd128, 8'd70};

    int phase_w[PHASES] = '{3, 1, 0, 2, 5, 3, 8, 7, 2, 9, 12, 4, 6, 16};
    int phase_h[PHASES] = '{3, 1, 0, 2, 4, 7, 3, 5, 9, 2, 6, 3, 6, 4};

    weighted_neighbor_compare_3x3_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_out_value   (o_out_value),
        .o_last_of_run (o_last_of_run)
    );

    wnc_result_check #(
        .MAX_WIDTH (4096)
    ) result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_row     (o_out_row),
        .i_out_col     (o_out_col),
        .i_out_value   (o_out_value),
        .i_out_last    (o_last_of_run),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("weighted_neighbor_compare_3x3_top verification failed");
            $finish;
        end
    end

    function automatic t_pix pick_pixel();
        case ($urandom_range(0, 3))
            0: return t_pix'($urandom_range(0, 1) * 255);
            1: return level + t_pix'($urandom_range(0, 2));
            default: return t_pix'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic set_idle(input int mode);
        case (mode)
            1: begin
                send_idle_pct = 80;
                stall_pct     = 0;
            end
            2: begin
                send_idle_pct = 0;
                stall_pct     = 80;
            end
            3: begin
                send_idle_pct = 31;
                stall_pct     = 31;
            end
            default: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
        endcase
    endtask

    // Valid stays up from one request to the next unless the sender idles.
    task automatic send_pixel(input t_pix pix, input logic fs);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel       <= pix;
        i_frame_start <= fs;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // The pending count is registered, so the task lets it update before trusting it.
    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= REG_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // A frame may continue across a new setting only when the width does not
    // grow; otherwise line buffer columns above would never have been written.
    task automatic run_phase(input int w, input int h, input int count, input int mode);
        logic restart;
        drain();
        set_idle(mode);
        restart = (w == 0) || (w > prev_width) || ($urandom_range(0, 1) == 1);
        set_dims(CFG_W'(w), CFG_W'(h));
        prev_width = w;
        level = t_pix'($urandom_range(0, 253));
        for (int k = 0; k < count; k++) begin
            send_pixel(pick_pixel(), (k == 0 && restart) || ($urandom_range(0, 99) < 2));
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A few first-row pixels under the reset dimensions.
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd170, 1'b0);
        send_pixel(8'd85, 1'b0);
        i_valid <= 1'b0;

        drain();
        set_dims(13'd4, 13'd4);
        prev_width = 4;
        for (int k = 0; k < 16; k++) send_pixel(probe_frame[k], k == 0);
        // The next frame is cut short by a restart in the middle of a row.
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        i_valid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            run_phase(phase_w[p], phase_h[p], PHASE_ITEMS, p % 4);
        end
        // A wide row, then a tall column, both through out-of-range settings.
        run_phase(8191, 0, WIDE_ITEMS, 0);
        run_phase(1, 4500, WIDE_ITEMS, 0);

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("weighted_neighbor_compare_3x3_top verification clean");
        end else begin
            $display("weighted_neighbor_compare_3x3_top verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/wnc_pkg.sv
rtl/wnc_front.sv
rtl/wnc_queue.sv
rtl/wnc_back.sv
rtl/weighted_neighbor_compare_3x3_top.sv
tb/wnc_result_check.sv
tb/tb_weighted_neighbor_compare_3x3_top.sv
